### sv/staggered_grid_interpolator_macros.svh
`ifndef STAGGERED_GRID_INTERPOLATOR_MACROS_SVH
`define STAGGERED_GRID_INTERPOLATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SGI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgi: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SGI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgi: next-cycle check failed");

`endif

### sv/sgi_pkg.sv
`default_nettype none

package sgi_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int MAX_ROWS      = 1024;
	localparam int ROW_BITS      = $clog2(MAX_ROWS);
	localparam int ROWS_REG_BITS = ROW_BITS + 1;
	localparam int COL_BITS      = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 2;
	localparam int ROWS_RESET    = 1024;
	localparam int COLS_RESET    = 1024;
	localparam int NRES          = 4;
	localparam int RES_IDX_BITS  = $clog2(NRES);
	// weights of an adjoint sum add up to at most nine
	localparam int ACC_BITS      = SAMPLE_BITS + 4;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MODE = 2'd0,
		REG_ROWS = 2'd1,
		REG_COLS = 2'd2
	} reg_idx_t;

	typedef enum logic {
		MODE_FWD = 1'b0,
		MODE_ADJ = 1'b1
	} mode_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [ACC_BITS-1:0] acc_t;

	typedef struct packed {
		sample_t in_vel_x;
		sample_t in_vel_z;
		sample_t in_stress_xx;
		sample_t in_stress_zz;
		sample_t in_stress_xz;
	} in_item_t;

	typedef struct packed {
		sample_t out_vel_x;
		sample_t out_vel_z;
		sample_t out_stress_xx;
		sample_t out_stress_zz;
		sample_t out_stress_xz;
		logic [COL_BITS-1:0] out_col;
		logic [ROW_BITS-1:0] out_row;
		logic last_of_run;
	} out_item_t;

	typedef struct packed {
		mode_t mode;
		logic xl;
		logic zl;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
	} calc_ctl_t;

	typedef struct packed {
		logic [NRES-1:0] mask;
		out_item_t [NRES-1:0] item;
	} res_set_t;

	function automatic sample_t avg2(sample_t a, sample_t b);
		logic [SAMPLE_BITS:0] s;
		s = {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
		return s[SAMPLE_BITS:1];
	endfunction

	function automatic sample_t avg4(sample_t a, sample_t b, sample_t c, sample_t d);
		logic [SAMPLE_BITS+1:0] s;
		s = {{2{a[SAMPLE_BITS-1]}}, a} + {{2{b[SAMPLE_BITS-1]}}, b}
			+ {{2{c[SAMPLE_BITS-1]}}, c} + {{2{d[SAMPLE_BITS-1]}}, d};
		return s[SAMPLE_BITS+1:2];
	endfunction

	function automatic acc_t acc_ext(sample_t s);
		return {{(ACC_BITS-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
	endfunction

	// floor(sum / 4), clamped to the sample range
	function automatic sample_t sat_quarter(acc_t sum);
		acc_t q;
		logic [ACC_BITS-SAMPLE_BITS:0] hi;
		q  = sum >>> 2;
		hi = q[ACC_BITS-1:SAMPLE_BITS-1];
		if ((&hi) || !(|hi)) begin
			return q[SAMPLE_BITS-1:0];
		end else if (q[ACC_BITS-1]) begin
			return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

### sv/sgi_ram.sv
`default_nettype none

module sgi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### sv/sgi_calc.sv
`default_nettype none

module sgi_calc (
	input  sgi_pkg::in_item_t  cur,
	input  sgi_pkg::in_item_t  left,
	input  sgi_pkg::in_item_t  up,
	input  sgi_pkg::in_item_t  diag,
	input  sgi_pkg::calc_ctl_t ctl,
	output sgi_pkg::res_set_t  res
);

	import sgi_pkg::*;

	function automatic out_item_t make_item(sample_t v0, sample_t v1, sample_t v2,
			sample_t v3, sample_t v4, logic [COL_BITS-1:0] col,
			logic [ROW_BITS-1:0] row);
		out_item_t o;
		o.out_vel_x     = v0;
		o.out_vel_z     = v1;
		o.out_stress_xx = v2;
		o.out_stress_zz = v3;
		o.out_stress_xz = v4;
		o.out_col       = col;
		o.out_row       = row;
		o.last_of_run   = 1'b0;
		return o;
	endfunction

	logic has_left;
	logic has_up;
	logic [COL_BITS-1:0] col_m1;
	logic [ROW_BITS-1:0] row_m1;
	logic [1:0] sh_x;
	logic [1:0] sh_z;
	logic [1:0] sh_xz;
	acc_t acc0;
	acc_t acc1;
	acc_t acc4;

	always_comb begin
		has_left = ctl.col != '0;
		has_up   = ctl.row != '0;
		col_m1   = COL_BITS'(ctl.col - 1'b1);
		row_m1   = ROW_BITS'(ctl.row - 1'b1);
		sh_x     = {1'b0, ctl.xl};
		sh_z     = {1'b0, ctl.zl};
		sh_xz    = sh_x + sh_z;

		// point one column and one row back: full 2x2 block
		res.item[0] = make_item(avg2(diag.in_vel_x, up.in_vel_x),
			avg2(diag.in_vel_z, left.in_vel_z), diag.in_stress_xx, diag.in_stress_zz,
			avg4(diag.in_stress_xz, left.in_stress_xz, up.in_stress_xz, cur.in_stress_xz),
			col_m1, row_m1);
		// previous column, last row
		res.item[1] = make_item(avg2(left.in_vel_x, cur.in_vel_x), left.in_vel_z,
			left.in_stress_xx, left.in_stress_zz,
			avg2(left.in_stress_xz, cur.in_stress_xz), ctl.col, ctl.row);
		res.item[1].out_col = col_m1;
		// last column, previous row
		res.item[2] = make_item(up.in_vel_x, avg2(up.in_vel_z, cur.in_vel_z),
			up.in_stress_xx, up.in_stress_zz,
			avg2(up.in_stress_xz, cur.in_stress_xz), ctl.col, row_m1);
		// corner point
		res.item[3] = make_item(cur.in_vel_x, cur.in_vel_z, cur.in_stress_xx,
			cur.in_stress_zz, cur.in_stress_xz, ctl.col, ctl.row);

		acc0 = (acc_ext(cur.in_vel_x) <<< (sh_x + 2'd1))
			+ (has_left ? (acc_ext(left.in_vel_x) <<< 1) : acc_t'(0));
		acc1 = (acc_ext(cur.in_vel_z) <<< (sh_z + 2'd1))
			+ (has_up ? (acc_ext(up.in_vel_z) <<< 1) : acc_t'(0));
		acc4 = (acc_ext(cur.in_stress_xz) <<< sh_xz)
			+ (has_up ? (acc_ext(up.in_stress_xz) <<< sh_x) : acc_t'(0))
			+ (has_left ? (acc_ext(left.in_stress_xz) <<< sh_z) : acc_t'(0))
			+ ((has_left && has_up) ? acc_ext(diag.in_stress_xz) : acc_t'(0));

		if (ctl.mode == MODE_ADJ) begin
			res.mask    = NRES'(1);
			res.item[0] = make_item(sat_quarter(acc0), sat_quarter(acc1),
				cur.in_stress_xx, cur.in_stress_zz, sat_quarter(acc4),
				ctl.col, ctl.row);
		end else begin
			res.mask = {ctl.xl && ctl.zl, ctl.xl && has_up,
				has_left && ctl.zl, has_left && has_up};
		end
	end

endmodule

`default_nettype wire

### sv/staggered_grid_interpolator.sv
// A taken input item is registered in stage s1; its results are registered in stage s2.
// Throughput: one item per cycle unless in_stall; in forward mode a last-row or last-column
// item gives up to two results (the last point of a frame four), one per cycle unless out_stall,
// while the input is held. The line buffer is one memory of MAX_ROWS entries, one write and
// one read a cycle. Reset clears control state and sets mode 0 with a 1024 x 1024 grid; the
// line buffer is not cleared, since no entry is used before it is written.
`default_nettype none

`include "staggered_grid_interpolator_macros.svh"

module staggered_grid_interpolator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sgi_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [sgi_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  sgi_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output sgi_pkg::out_item_t                 out_data
);

	import sgi_pkg::*;

	mode_t mode_q;
	logic [ROWS_REG_BITS-1:0] rows_q;
	logic [COL_BITS-1:0] cols_q;
	logic cfg_hit;
	logic [ROWS_REG_BITS-1:0] rows_eff;
	logic [ROW_BITS-1:0] last_row;
	logic [COL_BITS-1:0] last_col;

	logic [ROW_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_q;

	logic valid_s1;
	logic byp_s1;
	mode_t mode_s1;
	logic xl_s1;
	logic zl_s1;
	logic [COL_BITS-1:0] col_s1;
	logic [ROW_BITS-1:0] row_s1;
	in_item_t cur_s1;
	in_item_t prev_cur_q;
	in_item_t prev_left_q;

	logic [$bits(in_item_t)-1:0] ram_rd;
	in_item_t left;
	calc_ctl_t ctl;
	res_set_t res;

	logic [NRES-1:0] mask_s2;
	out_item_t [NRES-1:0] item_s2;
	logic [NRES-1:0] sel_1h;
	logic [RES_IDX_BITS-1:0] sel_idx;
	logic last;

	logic in_fire;
	logic out_fire;
	logic s1_go;
	logic s2_free;

	always_comb begin
		case (cfg_idx)
			REG_MODE, REG_ROWS, REG_COLS: cfg_hit = 1'b1;
			default: cfg_hit = 1'b0;
		endcase
		if (rows_q == '0) begin
			rows_eff = ROWS_REG_BITS'(1);
		end else if (rows_q > ROWS_REG_BITS'(MAX_ROWS)) begin
			rows_eff = ROWS_REG_BITS'(MAX_ROWS);
		end else begin
			rows_eff = rows_q;
		end
		last_row = ROW_BITS'(rows_eff - 1'b1);
		last_col = (cols_q == '0) ? '0 : COL_BITS'(cols_q - 1'b1);
	end

	// output side: lowest pending result goes first
	always_comb begin
		sel_idx = '0;
		for (int i = NRES - 1; i >= 0; i--) begin
			if (mask_s2[i]) begin
				sel_idx = RES_IDX_BITS'(i);
			end
		end
		sel_1h = mask_s2 & (~mask_s2 + 1'b1);
		last   = (mask_s2 & (mask_s2 - 1'b1)) == '0;
		out_data = item_s2[sel_idx];
		out_data.last_of_run = last;
	end

	assign out_valid = |mask_s2;
	assign out_fire  = out_valid && !out_stall;
	assign s2_free   = !out_valid || (out_fire && last);
	assign s1_go     = valid_s1 && ((res.mask == '0) || s2_free);
	assign in_stall  = valid_s1 && !s1_go;
	assign in_fire   = in_valid && !in_stall;

	// the previous item's write lands on the same row only with a single-row grid
	assign left = byp_s1 ? prev_cur_q : in_item_t'(ram_rd);

	always_comb begin
		ctl.mode = mode_s1;
		ctl.xl   = xl_s1;
		ctl.zl   = zl_s1;
		ctl.col  = col_s1;
		ctl.row  = row_s1;
	end

	sgi_ram #(
		.WIDTH($bits(in_item_t)),
		.DEPTH(MAX_ROWS)
	) u_line (
		.clk    (clk),
		.wr_en  (s1_go),
		.wr_addr(row_s1),
		.wr_data(cur_s1),
		.rd_en  (in_fire),
		.rd_addr(row_q),
		.rd_data(ram_rd)
	);

	sgi_calc u_calc (
		.cur (cur_s1),
		.left(left),
		.up  (prev_cur_q),
		.diag(prev_left_q),
		.ctl (ctl),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_FWD;
			rows_q   <= ROWS_REG_BITS'(ROWS_RESET);
			cols_q   <= COL_BITS'(COLS_RESET);
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
			mask_s2  <= '0;
		end else begin
			if (cfg_we && cfg_hit) begin
				case (cfg_idx)
					REG_MODE: mode_q <= mode_t'(cfg_data[0]);
					REG_ROWS: rows_q <= cfg_data[ROWS_REG_BITS-1:0];
					REG_COLS: cols_q <= cfg_data;
					default: ;
				endcase
				// restart the frame
				row_q <= '0;
				col_q <= '0;
			end else if (in_fire) begin
				if (row_q == last_row) begin
					row_q <= '0;
					col_q <= (col_q == last_col) ? '0 : COL_BITS'(col_q + 1'b1);
				end else begin
					row_q <= ROW_BITS'(row_q + 1'b1);
				end
			end

			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end

			if (s1_go && (res.mask != '0)) begin
				mask_s2 <= res.mask;
			end else if (out_fire) begin
				mask_s2 <= mask_s2 & ~sel_1h;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cur_s1  <= in_data;
			col_s1  <= col_q;
			row_s1  <= row_q;
			xl_s1   <= col_q == last_col;
			zl_s1   <= row_q == last_row;
			mode_s1 <= mode_q;
			byp_s1  <= s1_go && (row_s1 == row_q);
		end
		if (s1_go) begin
			prev_cur_q  <= cur_s1;
			prev_left_q <= left;
		end
		if (s1_go && (res.mask != '0)) begin
			item_s2 <= res.item;
		end
	end

	`SGI_ASSERT_NEXT(a_more_pending, clk, arst_n, out_fire && !last, out_valid)
	`SGI_ASSERT_SAME(a_bypass_row, clk, arst_n, valid_s1 && byp_s1, row_s1 == '0)
	`SGI_ASSERT_SAME(a_first_col_quiet, clk, arst_n,
		valid_s1 && (mode_s1 == MODE_FWD) && (col_s1 == '0) && !xl_s1, res.mask == '0)
	`SGI_ASSERT_SAME(a_adj_single, clk, arst_n,
		valid_s1 && (mode_s1 == MODE_ADJ), $onehot(res.mask))

endmodule

`default_nettype wire

### tb/staggered_grid_interpolator_tb.sv
`default_nettype none

module staggered_grid_interpolator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sgi_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam sample_t SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam int SETTLE      = 4;
	localparam int RAND_ITEMS  = 150;
	localparam int CALM_ITEMS  = 30;

	typedef struct {
		bit                       is_cfg;
		logic [CFG_IDX_BITS-1:0]  idx;
		logic [CFG_DATA_BITS-1:0] val;
		in_item_t                 pt;
		bit                       typed;
		out_item_t                want;
	} plan_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_idx;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	in_item_t                 in_data;
	logic                     out_valid;
	logic                     out_stall;
	out_item_t                out_data;

	// grid model state
	mode_t     grid_mode;
	int        rows_reg;
	int        cols_reg;
	int        pos_col;
	int        pos_row;
	in_item_t  line_buf [0:MAX_ROWS];
	out_item_t results_due [$];
	plan_row_t plan [$];

	int mismatches   = 0;
	int results_seen = 0;
	int items_sent   = 0;
	int writes_done  = 0;
	int idle_odds    = 0;

	staggered_grid_interpolator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint sx(sample_t s);
		return longint'(s);
	endfunction

	// floor of s/4, clamped to the sample range
	function automatic sample_t floor_quarter(longint s);
		longint q;
		q = s >>> 2;
		if (q > sx(SMAX))
			q = sx(SMAX);
		else if (q < sx(SMIN))
			q = sx(SMIN);
		return sample_t'(q);
	endfunction

	function automatic in_item_t pt(sample_t a, sample_t b, sample_t c, sample_t d, sample_t e);
		return '{a, b, c, d, e};
	endfunction

	function automatic in_item_t flat(sample_t v);
		return pt(v, v, v, v, v);
	endfunction

	// a: the point, b: next row, rt: next column, d: diagonal
	function automatic out_item_t fwd_sample_point(in_item_t a, in_item_t b, in_item_t rt,
			in_item_t d, bit xl, bit zl, int col, int row);
		out_item_t o;
		o.out_vel_x = xl ? a.in_vel_x
			: floor_quarter(2 * (sx(a.in_vel_x) + sx(rt.in_vel_x)));
		o.out_vel_z = zl ? a.in_vel_z
			: floor_quarter(2 * (sx(a.in_vel_z) + sx(b.in_vel_z)));
		o.out_stress_xx = a.in_stress_xx;
		o.out_stress_zz = a.in_stress_zz;
		if (xl && zl)
			o.out_stress_xz = a.in_stress_xz;
		else if (xl)
			o.out_stress_xz = floor_quarter(2 * (sx(a.in_stress_xz) + sx(b.in_stress_xz)));
		else if (zl)
			o.out_stress_xz = floor_quarter(2 * (sx(a.in_stress_xz) + sx(rt.in_stress_xz)));
		else
			o.out_stress_xz = floor_quarter(sx(a.in_stress_xz) + sx(b.in_stress_xz)
				+ sx(rt.in_stress_xz) + sx(d.in_stress_xz));
		o.out_col     = COL_BITS'(col);
		o.out_row     = ROW_BITS'(row);
		o.last_of_run = 1'b0;
		return o;
	endfunction

	function automatic void apply_cfg(logic [CFG_IDX_BITS-1:0] idx,
			logic [CFG_DATA_BITS-1:0] v);
		case (idx)
			REG_MODE: grid_mode = mode_t'(v[0]);
			REG_ROWS: rows_reg = int'(v[ROWS_REG_BITS-1:0]);
			REG_COLS: cols_reg = int'(v);
			default: return;
		endcase
		pos_col = 0;
		pos_row = 0;
	endfunction

	// advance the grid by one point; queue its results when keep is set
	function automatic void interp_step(in_item_t x, bit keep);
		int        nr, nc, c, r, n;
		longint    hx, hz, s0, s1, s4;
		bit        xl, zl;
		in_item_t  lft, up, dg;
		out_item_t res [4];
		nr = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
		nc = (cols_reg == 0) ? 1 : cols_reg;
		if (pos_row >= nr || pos_col >= nc) begin
			pos_row = 0;
			pos_col = 0;
		end
		c  = pos_col;
		r  = pos_row;
		xl = (c == nc - 1);
		zl = (r == nr - 1);
		dg  = line_buf[MAX_ROWS];
		lft = line_buf[r];
		up  = line_buf[(r > 0) ? r - 1 : 0];
		line_buf[MAX_ROWS] = lft;
		line_buf[r]        = x;
		n = 0;
		if (grid_mode == MODE_FWD) begin
			if (c >= 1 && r >= 1) begin
				res[n] = fwd_sample_point(dg, lft, up, x, 1'b0, 1'b0, c - 1, r - 1);
				n++;
			end
			if (c >= 1 && zl) begin
				res[n] = fwd_sample_point(lft, lft, x, x, 1'b0, 1'b1, c - 1, r);
				n++;
			end
			if (xl && r >= 1) begin
				res[n] = fwd_sample_point(up, x, up, x, 1'b1, 1'b0, c, r - 1);
				n++;
			end
			if (xl && zl) begin
				res[n] = fwd_sample_point(x, x, x, x, 1'b1, 1'b1, c, r);
				n++;
			end
		end else begin
			hx = xl ? 2 : 1;
			hz = zl ? 2 : 1;
			s0 = (xl ? 4 : 2) * sx(x.in_vel_x);
			if (c >= 1)
				s0 += 2 * sx(lft.in_vel_x);
			s1 = (zl ? 4 : 2) * sx(x.in_vel_z);
			if (r >= 1)
				s1 += 2 * sx(up.in_vel_z);
			s4 = hx * hz * sx(x.in_stress_xz);
			if (r >= 1)
				s4 += hx * sx(up.in_stress_xz);
			if (c >= 1)
				s4 += hz * sx(lft.in_stress_xz);
			if (c >= 1 && r >= 1)
				s4 += sx(dg.in_stress_xz);
			res[0].out_vel_x     = floor_quarter(s0);
			res[0].out_vel_z     = floor_quarter(s1);
			res[0].out_stress_xx = x.in_stress_xx;
			res[0].out_stress_zz = x.in_stress_zz;
			res[0].out_stress_xz = floor_quarter(s4);
			res[0].out_col       = COL_BITS'(c);
			res[0].out_row       = ROW_BITS'(r);
			res[0].last_of_run   = 1'b0;
			n = 1;
		end
		if (n > 0)
			res[n-1].last_of_run = 1'b1;
		if (keep) begin
			for (int i = 0; i < n; i++)
				results_due.push_back(res[i]);
		end
		r++;
		if (r >= nr) begin
			r = 0;
			c++;
			if (c >= nc)
				c = 0;
		end
		pos_row = r;
		pos_col = c;
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 7))
			0: return SMAX;
			1: return SMIN;
			2: return $urandom_range(0, 1) ? '1 : '0;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_point();
		return pt(rand_sample(), rand_sample(), rand_sample(), rand_sample(), rand_sample());
	endfunction

	function automatic plan_row_t cfg_row(logic [CFG_IDX_BITS-1:0] idx,
			logic [CFG_DATA_BITS-1:0] v);
		plan_row_t p;
		p.is_cfg = 1'b1;
		p.idx    = idx;
		p.val    = v;
		p.pt     = '0;
		p.typed  = 1'b0;
		p.want   = '0;
		return p;
	endfunction

	function automatic plan_row_t pt_row(in_item_t x);
		plan_row_t p;
		p        = cfg_row(REG_MODE, '0);
		p.is_cfg = 1'b0;
		p.pt     = x;
		return p;
	endfunction

	// the point comes back unchanged (copy or full saturation)
	function automatic plan_row_t copy_row(in_item_t x, int col, int row);
		plan_row_t p;
		p                    = pt_row(x);
		p.typed              = 1'b1;
		p.want.out_vel_x     = x.in_vel_x;
		p.want.out_vel_z     = x.in_vel_z;
		p.want.out_stress_xx = x.in_stress_xx;
		p.want.out_stress_zz = x.in_stress_zz;
		p.want.out_stress_xz = x.in_stress_xz;
		p.want.out_col       = COL_BITS'(col);
		p.want.out_row       = ROW_BITS'(row);
		p.want.last_of_run   = 1'b1;
		return p;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// write only with nothing in flight
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_cfg(idx, v);
		writes_done++;
	endtask

	task automatic send_point(in_item_t x, bit typed, out_item_t want);
		bit took;
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= x;
		do begin
			@(negedge clk);
			took = (in_stall === 1'b0);
			@(posedge clk);
		end while (!took);
		interp_step(x, !typed);
		if (typed)
			results_due.push_back(want);
		items_sent++;
	endtask

	// receiver stalls in bursts
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// sample mid-cycle: these are the values seen at the next rising edge
	initial begin
		out_item_t got, want;
		forever begin
			@(negedge clk);
			if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
				got = out_data;
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result at col %0d row %0d", $time,
						got.out_col, got.out_row);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("out_vel_x", sx(want.out_vel_x), sx(got.out_vel_x));
					check_field("out_vel_z", sx(want.out_vel_z), sx(got.out_vel_z));
					check_field("out_stress_xx", sx(want.out_stress_xx), sx(got.out_stress_xx));
					check_field("out_stress_zz", sx(want.out_stress_zz), sx(got.out_stress_zz));
					check_field("out_stress_xz", sx(want.out_stress_xz), sx(got.out_stress_xz));
					check_field("out_col", longint'(want.out_col), longint'(got.out_col));
					check_field("out_row", longint'(want.out_row), longint'(got.out_row));
					check_field("last_of_run", longint'(want.last_of_run),
						longint'(got.last_of_run));
					results_seen++;
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int                       count, eff_rows, eff_cols, rand_items, directed_items;
		logic [ROWS_REG_BITS-1:0] rows_pick;
		logic [CFG_DATA_BITS-1:0] cols_pick;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_idx   <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_stall <= 1'b0;
		grid_mode = MODE_FWD;
		rows_reg  = ROWS_RESET;
		cols_reg  = COLS_RESET;
		pos_col   = 0;
		pos_row   = 0;
		foreach (line_buf[i])
			line_buf[i] = '0;

		// single point grid: every point is copied straight through
		plan.push_back(cfg_row(REG_ROWS, 16'd1));
		plan.push_back(cfg_row(REG_COLS, 16'd1));
		plan.push_back(copy_row(flat(SMAX), 0, 0));
		plan.push_back(copy_row(flat(SMIN), 0, 0));
		plan.push_back(copy_row(pt('0, '1, 24'sd1, SMAX, SMIN), 0, 0));
		plan.push_back(cfg_row(REG_MODE, 16'(MODE_ADJ)));
		plan.push_back(copy_row(flat(SMAX), 0, 0));
		plan.push_back(copy_row(flat(SMIN), 0, 0));
		// 2x2 adjoint: the corner saturates; a write to the spare index keeps the frame
		plan.push_back(cfg_row(REG_ROWS, 16'd2));
		plan.push_back(cfg_row(REG_COLS, 16'd2));
		plan.push_back(pt_row(flat(SMAX)));
		plan.push_back(pt_row(flat(SMAX)));
		plan.push_back(pt_row(flat(SMAX)));
		plan.push_back(cfg_row(REG_UNUSED, 16'hffff));
		plan.push_back(copy_row(flat(SMAX), 1, 1));
		plan.push_back(pt_row(flat(SMIN)));
		plan.push_back(pt_row(flat(SMIN)));
		plan.push_back(pt_row(flat(SMIN)));
		plan.push_back(copy_row(flat(SMIN), 1, 1));
		// 2x2 forward: the last point releases four results
		plan.push_back(cfg_row(REG_MODE, 16'(MODE_FWD)));
		plan.push_back(pt_row(pt(SMAX, SMIN, 24'sd1, '1, SMAX)));
		plan.push_back(pt_row(pt(SMIN, SMAX, '1, 24'sd1, SMIN)));
		plan.push_back(pt_row(pt(SMAX, SMAX, '0, '0, SMIN)));
		plan.push_back(pt_row(pt('1, '1, SMAX, SMIN, '1)));
		// zero sizes act as one
		plan.push_back(cfg_row(REG_ROWS, 16'd0));
		plan.push_back(cfg_row(REG_COLS, 16'd0));
		plan.push_back(copy_row(pt(SMIN, SMAX, '0, '1, 24'sd1), 0, 0));
		// rows above the bound act as the bound
		plan.push_back(cfg_row(REG_ROWS, 16'hffff));
		plan.push_back(cfg_row(REG_COLS, 16'd3));
		plan.push_back(pt_row(rand_point()));
		plan.push_back(pt_row(rand_point()));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_odds = 3;
		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].val);
			else
				send_point(plan[i].pt, plan[i].typed, plan[i].want);
		end
		directed_items = items_sent;

		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			if (rand_items >= RAND_ITEMS - CALM_ITEMS) begin
				idle_odds = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: idle_odds = 0;
					1: idle_odds = 2;
					2: idle_odds = 4;
					default: idle_odds = 10;
				endcase
			end
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_MODE, {15'($urandom), 1'($urandom)});
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: rows_pick = ROWS_REG_BITS'(MAX_ROWS);
					1: rows_pick = '0;
					2: rows_pick = '1;
					3: rows_pick = ROWS_REG_BITS'($urandom);
					default: rows_pick = ROWS_REG_BITS'($urandom_range(1, 6));
				endcase
				write_reg(REG_ROWS, {(CFG_DATA_BITS-ROWS_REG_BITS)'($urandom), rows_pick});
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: cols_pick = '0;
					1: cols_pick = '1;
					2: cols_pick = CFG_DATA_BITS'($urandom);
					default: cols_pick = CFG_DATA_BITS'($urandom_range(1, 6));
				endcase
				write_reg(REG_COLS, cols_pick);
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));

			// small grids get whole frames, so every neighbour case shows up
			eff_rows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
			eff_cols = (cols_reg == 0) ? 1 : cols_reg;
			if (eff_rows * eff_cols <= 30)
				count = eff_rows * eff_cols * $urandom_range(1, 2) + $urandom_range(0, 2);
			else
				count = $urandom_range(4, 24);
			if (count > RAND_ITEMS - rand_items)
				count = RAND_ITEMS - rand_items;
			repeat (count) begin
				send_point(rand_point(), 1'b0, '0);
				rand_items++;
			end
		end
		in_valid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Streamed %0d grid points (%0d directed) through %0d register writes,",
			items_sent, directed_items, writes_done);
		$display("forward and adjoint; %0d results checked, %0d mismatches.",
			results_seen, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
+incdir+sv
sv/sgi_pkg.sv
sv/sgi_ram.sv
sv/sgi_calc.sv
sv/staggered_grid_interpolator.sv
tb/staggered_grid_interpolator_tb.sv
